### sv/dpp_pkg.sv
package dpp_pkg;

	localparam int COORD_FRAC_BITS_DEF = 12;
	localparam int NORM_FRAC = 24;
	localparam int K_FRAC = 30;

	localparam logic [2:0] REG_HOM_A_B = 3'd0;
	localparam logic [2:0] REG_HOM_C_D = 3'd1;
	localparam logic [2:0] REG_HOM_E_F = 3'd2;
	localparam logic [2:0] REG_HOM_G_H = 3'd3;
	localparam logic [2:0] REG_HOM_I = 3'd4;
	localparam logic [2:0] REG_RADIAL = 3'd5;
	localparam logic [2:0] REG_IMG_W = 3'd6;
	localparam logic [2:0] REG_IMG_H = 3'd7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [31:0] obj_x;
		logic signed [31:0] obj_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pixel_x;
		logic signed [31:0] pixel_y;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [63:0] hom_a_b;
		logic [63:0] hom_c_d;
		logic [63:0] hom_e_f;
		logic [63:0] hom_g_h;
		logic signed [31:0] hom_i;
		logic [63:0] radial_coeffs;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} cfg_t;

	// Pipeline control record: valid, zero and saturation flags.
	typedef struct packed {
		logic vld;
		logic zero;
		logic sat;
	} ctl_t;

endpackage

### sv/dpp_div.sv
// Pipelined restoring divider: quotient of a by b, one bit per stage,
// magnitude only. Valid and tag travel with the data; en stalls all stages.
module dpp_div import dpp_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 64,
	parameter int QW = 34,
	parameter int TW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [NW-1:0] a,
	input logic [DW-1:0] b,
	input logic [TW-1:0] tag_in,
	output logic out_vld,
	output logic [QW-1:0] q,
	output logic [TW-1:0] tag_out
);
	// The numerator sits at the top so that its leading QW bits are brought
	// into the remainder one per stage; quotient bits fill in from the bottom.
	localparam int RW = DW + 1;

	logic vld_s [QW+1];
	logic [RW-1:0] rem_s [QW+1];
	logic [NW+QW-1:0] num_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [TW-1:0] tag_s [QW+1];

	always_comb begin
		vld_s[0] = in_vld;
		rem_s[0] = '0;
		num_s[0] = {a, {QW{1'b0}}};
		den_s[0] = b;
		tag_s[0] = tag_in;
	end

	for (genvar i = 0; i < QW; i++) begin : g_st
		logic [RW-1:0] trial;
		logic [RW-1:0] diff;
		logic [RW-1:0] rem_nx;
		assign trial = {rem_s[i][RW-2:0], num_s[i][NW+QW-1]};
		assign diff = trial - {1'b0, den_s[i]};
		assign rem_nx = (trial >= {1'b0, den_s[i]}) ? diff : trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_nx;
				num_s[i+1] <= {num_s[i][NW+QW-2:0], (trial >= {1'b0, den_s[i]})};
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign q = num_s[QW][QW-1:0];
	assign tag_out = tag_s[QW];
endmodule

### sv/dpp_regs.sv
module dpp_regs import dpp_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data,
	output cfg_t cfg
);
	localparam logic [31:0] ONE = 32'd1 << COORD_FRAC_BITS;
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hom_a_b <= {ONE, 32'd0};
			cfg_q.hom_c_d <= '0;
			cfg_q.hom_e_f <= {ONE, 32'd0};
			cfg_q.hom_g_h <= '0;
			cfg_q.hom_i <= ONE;
			cfg_q.radial_coeffs <= '0;
			cfg_q.image_width <= 16'd640;
			cfg_q.image_height <= 16'd480;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HOM_A_B: cfg_q.hom_a_b <= cfg_data;
				REG_HOM_C_D: cfg_q.hom_c_d <= cfg_data;
				REG_HOM_E_F: cfg_q.hom_e_f <= cfg_data;
				REG_HOM_G_H: cfg_q.hom_g_h <= cfg_data;
				REG_HOM_I: cfg_q.hom_i <= cfg_data[31:0];
				REG_RADIAL: cfg_q.radial_coeffs <= cfg_data;
				REG_IMG_W: cfg_q.image_width <= cfg_data[15:0];
				REG_IMG_H: cfg_q.image_height <= cfg_data[15:0];
				default: ;
			endcase
		end
	end
endmodule

### sv/distorted_point_projection_top.sv
// Distorted point projection.
// Input channel (in_valid/in_stall/in_item) takes one target point per
// cycle while in_stall is low; output channel (out_valid/out_stall/
// out_item) returns one pixel item per point, in order. The item is
// mapped through the homography, divided by z in a bit-per-stage
// pipelined divider, normalized against the half image size in a
// second divider, radially scaled and denormalized. The item passes
// through 151 registers for any COORD_FRAC_BITS: three front stages,
// 65+F projective divider stages, one stage, 73-F normalize divider
// stages, eight back stages and the output register. A stall holds
// every item in its register. Throughput is one item per cycle while
// no stall is present.
// The configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is
// always ready and must be written only while no item is in flight.
// Reset clears all valid bits and loads the identity homography, zero
// distortion and a 640 by 480 image.
// A stall at the output while out_valid is high freezes the whole pipeline; in_stall follows it,
// so no item is lost or repeated.
module distorted_point_projection_top import dpp_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);
	localparam int F = COORD_FRAC_BITS;
	localparam int NSH = NORM_FRAC - F;

	cfg_t cfg;
	logic en;
	logic out_vld_q;
	out_item_t out_q;

	dpp_regs #(.COORD_FRAC_BITS(F)) u_regs (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
	);

	// Whole pipeline advances unless the output register is full and held.
	assign en = !(out_vld_q && out_stall);
	assign in_stall = !en;

	logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	logic signed [31:0] k1, k2;
	logic [14:0] hw, hh;
	assign h00 = cfg.hom_a_b[63:32];
	assign h01 = cfg.hom_a_b[31:0];
	assign h02 = cfg.hom_c_d[63:32];
	assign h10 = cfg.hom_c_d[31:0];
	assign h11 = cfg.hom_e_f[63:32];
	assign h12 = cfg.hom_e_f[31:0];
	assign h20 = cfg.hom_g_h[63:32];
	assign h21 = cfg.hom_g_h[31:0];
	assign h22 = cfg.hom_i;
	assign k1 = cfg.radial_coeffs[63:32];
	assign k2 = cfg.radial_coeffs[31:0];
	assign hw = (cfg.image_width[15:1] == '0) ? 15'd1 : cfg.image_width[15:1];
	assign hh = (cfg.image_height[15:1] == '0) ? 15'd1 : cfg.image_height[15:1];

	// Stage 1: six products.
	logic v1;
	logic signed [63:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1 <= 1'b0;
		else if (en) v1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(h00) * 64'(in_item.obj_x);
			p01_s1 <= 64'(h01) * 64'(in_item.obj_y);
			p10_s1 <= 64'(h10) * 64'(in_item.obj_x);
			p11_s1 <= 64'(h11) * 64'(in_item.obj_y);
			p20_s1 <= 64'(h20) * 64'(in_item.obj_x);
			p21_s1 <= 64'(h21) * 64'(in_item.obj_y);
		end
	end

	// Stage 2: halved sums.
	logic v2;
	logic signed [64:0] u_s2, vv_s2, z_s2;
	logic signed [63:0] c0, c1, c2;
	assign c0 = 64'(h02) <<< F;
	assign c1 = 64'(h12) <<< F;
	assign c2 = 64'(h22) <<< F;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2 <= 1'b0;
		else if (en) v2 <= v1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			u_s2 <= 65'(p00_s1 >>> 1) + 65'(p01_s1 >>> 1) + 65'(c0 >>> 1);
			vv_s2 <= 65'(p10_s1 >>> 1) + 65'(p11_s1 >>> 1) + 65'(c1 >>> 1);
			z_s2 <= 65'(p20_s1 >>> 1) + 65'(p21_s1 >>> 1) + 65'(c2 >>> 1);
		end
	end

	// Stage 3: magnitudes and signs for the projective divide.
	logic v3;
	logic [64:0] ua_s3, va_s3, za_s3;
	logic un_s3, vn_s3, zero_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3 <= 1'b0;
		else if (en) v3 <= v2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ua_s3 <= u_s2[64] ? -u_s2 : u_s2;
			va_s3 <= vv_s2[64] ? -vv_s2 : vv_s2;
			za_s3 <= z_s2[64] ? -z_s2 : z_s2;
			un_s3 <= u_s2[64] ^ z_s2[64];
			vn_s3 <= vv_s2[64] ^ z_s2[64];
			zero_s3 <= (z_s2 == '0);
		end
	end

	// Projective divide: full quotient of |n|*2^F by |z|; values beyond
	// the signed 32-bit range are clamped in the next stage.
	localparam int PNW = 65 + F;
	localparam int PQW = PNW;
	localparam int PTW = 3;
	logic [PNW-1:0] pnum_x, pnum_y;
	logic [64:0] pden;
	assign pden = (za_s3 == '0) ? 65'd1 : za_s3;
	assign pnum_x = {ua_s3, {F{1'b0}}};
	assign pnum_y = {va_s3, {F{1'b0}}};
	logic dvx, dvy;
	logic [PQW-1:0] qx, qy;
	logic [PTW-1:0] tx, ty;
	dpp_div #(.NW(PNW), .DW(65), .QW(PQW), .TW(PTW)) u_divx (
		.clk, .arst_n, .en, .in_vld(v3), .a(pnum_x), .b(pden),
		.tag_in({un_s3, vn_s3, zero_s3}), .out_vld(dvx), .q(qx), .tag_out(tx)
	);
	dpp_div #(.NW(PNW), .DW(65), .QW(PQW), .TW(PTW)) u_divy (
		.clk, .arst_n, .en, .in_vld(v3), .a(pnum_y), .b(pden),
		.tag_in({un_s3, vn_s3, zero_s3}), .out_vld(dvy), .q(qy), .tag_out(ty)
	);

	// Stage 4: signed clamp of px, py; subtract the half size.
	function automatic logic signed [32:0] sclamp(input logic [PQW-1:0] m,
			input logic neg, output logic sat);
		logic big;
		big = (m > PQW'(64'h80000000)) || (!neg && m == PQW'(64'h80000000));
		sat = big;
		if (neg) sclamp = big ? -33'sh80000000 : -$signed({1'b0, m[31:0]});
		else sclamp = big ? 33'sh7fffffff : $signed({1'b0, m[31:0]});
	endfunction

	logic v4, zero_s4, sat_s4;
	logic signed [48:0] dx_s4, dy_s4;
	logic signed [32:0] pxc, pyc;
	logic sx, sy;
	always_comb begin
		pxc = sclamp(qx, tx[2], sx);
		pyc = sclamp(qy, ty[1], sy);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v4 <= 1'b0;
		else if (en) v4 <= dvx & dvy;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= tx[0];
			sat_s4 <= sx | sy;
			dx_s4 <= 49'(pxc) - (49'(hw) <<< F);
			dy_s4 <= 49'(pyc) - (49'(hh) <<< F);
		end
	end

	// Normalize divide: |d|*2^(24-F) / half, truncated toward zero.
	localparam int NNW = 49 + NSH;
	localparam int NTW = 4;
	logic [48:0] dxa, dya;
	assign dxa = dx_s4[48] ? 49'(-dx_s4) : 49'(dx_s4);
	assign dya = dy_s4[48] ? 49'(-dy_s4) : 49'(dy_s4);
	logic nvx, nvy;
	logic [NNW-1:0] nqx, nqy;
	logic [NTW-1:0] ntx, nty;
	dpp_div #(.NW(NNW), .DW(15), .QW(NNW), .TW(NTW)) u_normx (
		.clk, .arst_n, .en, .in_vld(v4), .a({dxa, {NSH{1'b0}}}), .b(hw),
		.tag_in({dx_s4[48], dy_s4[48], zero_s4, sat_s4}), .out_vld(nvx),
		.q(nqx), .tag_out(ntx)
	);
	dpp_div #(.NW(NNW), .DW(15), .QW(NNW), .TW(NTW)) u_normy (
		.clk, .arst_n, .en, .in_vld(v4), .a({dya, {NSH{1'b0}}}), .b(hh),
		.tag_in({dx_s4[48], dy_s4[48], zero_s4, sat_s4}), .out_vld(nvy),
		.q(nqy), .tag_out(nty)
	);

	// Stage 5: clamp normalized coordinates.
	localparam logic [NNW-1:0] NLIM = NNW'((64'd1 << 27) - 1);
	logic v5, zero_s5, sat_s5;
	logic signed [28:0] nx_s5, ny_s5;
	logic [26:0] mx, my;
	assign mx = (nqx > NLIM) ? NLIM[26:0] : nqx[26:0];
	assign my = (nqy > NLIM) ? NLIM[26:0] : nqy[26:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v5 <= 1'b0;
		else if (en) v5 <= nvx & nvy;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= ntx[1];
			sat_s5 <= ntx[0] | (nqx > NLIM) | (nqy > NLIM);
			nx_s5 <= ntx[3] ? -$signed({2'b0, mx}) : $signed({2'b0, mx});
			ny_s5 <= nty[2] ? -$signed({2'b0, my}) : $signed({2'b0, my});
		end
	end

	// Stage 6: squares.
	logic v6, zero_s6, sat_s6;
	logic signed [28:0] nx_s6, ny_s6;
	logic [53:0] sqx_s6, sqy_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v6 <= 1'b0;
		else if (en) v6 <= v5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= zero_s5;
			sat_s6 <= sat_s5;
			nx_s6 <= nx_s5;
			ny_s6 <= ny_s5;
			sqx_s6 <= 54'(nx_s5) * 54'(nx_s5);
			sqy_s6 <= 54'(ny_s5) * 54'(ny_s5);
		end
	end

	// Stage 7: r2.
	logic v7, zero_s7, sat_s7;
	logic signed [28:0] nx_s7, ny_s7;
	logic [30:0] r2_s7;
	logic [54:0] sq_sum;
	assign sq_sum = 55'(sqx_s6) + 55'(sqy_s6);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v7 <= 1'b0;
		else if (en) v7 <= v6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s7 <= zero_s6;
			sat_s7 <= sat_s6;
			nx_s7 <= nx_s6;
			ny_s7 <= ny_s6;
			r2_s7 <= sq_sum[54:24];
		end
	end

	// Stage 8: k1*r2 and k2*r2.
	logic v8, zero_s8, sat_s8;
	logic signed [28:0] nx_s8, ny_s8;
	logic [30:0] r2_s8;
	logic signed [63:0] a1_s8, a2_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v8 <= 1'b0;
		else if (en) v8 <= v7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s8 <= zero_s7;
			sat_s8 <= sat_s7;
			nx_s8 <= nx_s7;
			ny_s8 <= ny_s7;
			r2_s8 <= r2_s7;
			a1_s8 <= 64'(k1) * 64'($signed({1'b0, r2_s7}));
			a2_s8 <= 64'(k2) * 64'($signed({1'b0, r2_s7}));
		end
	end

	// Stage 9: t*r2.
	logic v9, zero_s9, sat_s9;
	logic signed [28:0] nx_s9, ny_s9;
	logic signed [33:0] t1_s9;
	logic signed [64:0] b2_s9;
	logic signed [63:0] a1sh, a2sh;
	assign a1sh = a1_s8 >>> K_FRAC;
	assign a2sh = a2_s8 >>> K_FRAC;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v9 <= 1'b0;
		else if (en) v9 <= v8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s9 <= zero_s8;
			sat_s9 <= sat_s8;
			nx_s9 <= nx_s8;
			ny_s9 <= ny_s8;
			t1_s9 <= a1sh[33:0];
			b2_s9 <= 65'($signed(a2sh[33:0])) * 65'($signed({1'b0, r2_s8}));
		end
	end

	// Stage 10: dr with clamp.
	localparam logic signed [41:0] DRL = (42'sd1 <<< 35) - 42'sd1;
	logic v10, zero_s10, sat_s10;
	logic signed [28:0] nx_s10, ny_s10;
	logic signed [35:0] dr_s10;
	logic signed [64:0] b2sh;
	logic signed [41:0] drsum;
	assign b2sh = b2_s9 >>> NORM_FRAC;
	assign drsum = (42'sd1 <<< NORM_FRAC) + 42'(t1_s9) + 42'($signed(b2sh[40:0]));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v10 <= 1'b0;
		else if (en) v10 <= v9;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s10 <= zero_s9;
			nx_s10 <= nx_s9;
			ny_s10 <= ny_s9;
			sat_s10 <= sat_s9 | (drsum > DRL) | (drsum < -DRL);
			if (drsum > DRL) dr_s10 <= DRL[35:0];
			else if (drsum < -DRL) dr_s10 <= 36'(-DRL);
			else dr_s10 <= drsum[35:0];
		end
	end

	// Stage 11: n*dr (29 by 36 bits).
	logic v11, zero_s11, sat_s11;
	logic signed [64:0] mx_s11, my_s11;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v11 <= 1'b0;
		else if (en) v11 <= v10;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s11 <= zero_s10;
			sat_s11 <= sat_s10;
			mx_s11 <= 65'(nx_s10) * 65'(dr_s10);
			my_s11 <= 65'(ny_s10) * 65'(dr_s10);
		end
	end

	// Stage 12: s*half.
	logic v12, zero_s12, sat_s12;
	logic signed [57:0] ox_s12, oy_s12;
	logic signed [64:0] sxw, syw;
	assign sxw = mx_s11 >>> NORM_FRAC;
	assign syw = my_s11 >>> NORM_FRAC;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v12 <= 1'b0;
		else if (en) v12 <= v11;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s12 <= zero_s11;
			sat_s12 <= sat_s11;
			ox_s12 <= 58'($signed(sxw[41:0])) * 58'($signed({1'b0, hw}));
			oy_s12 <= 58'($signed(syw[41:0])) * 58'($signed({1'b0, hh}));
		end
	end

	// Stage 13: shift, add half, clamp and form the result item.
	logic signed [58:0] fx, fy;
	logic ovx, ovy;
	assign fx = 59'(ox_s12 >>> NSH) + (59'(hw) <<< F);
	assign fy = 59'(oy_s12 >>> NSH) + (59'(hh) <<< F);
	assign ovx = (fx > 59'sh7fffffff) || (fx < -59'sh80000000);
	assign ovy = (fy > 59'sh7fffffff) || (fy < -59'sh80000000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= v12;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s12) begin
				out_q.pixel_x <= '0;
				out_q.pixel_y <= '0;
				out_q.status <= ST_DIV_ZERO;
			end else begin
				out_q.pixel_x <= ovx ? (fx[58] ? 32'sh80000000 : 32'sh7fffffff) : fx[31:0];
				out_q.pixel_y <= ovy ? (fy[58] ? 32'sh80000000 : 32'sh7fffffff) : fy[31:0];
				out_q.status <= (sat_s12 | ovx | ovy) ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_item = out_q;
endmodule
